// ===== rtl/core/bmhq_pkg.sv =====
// bmhq_pkg: shared types and codes for the binary min-heap queue
// used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package bmhq_pkg;

    // action codes of an input item
    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // fixed port widths of the payload
    localparam int KEY_PORT_W   = 32;
    localparam int COUNT_PORT_W = 11;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_POP_LOAD,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

    // heap write data select
    typedef enum logic [1:0] {
        WR_NONE,
        WR_KEY,
        WR_PARENT,
        WR_CHILD
    } wr_sel_t;

    // heap read address select
    typedef enum logic [1:0] {
        RD_POP,
        RD_PARENT,
        RD_CHILD
    } rd_sel_t;

    typedef struct packed {
        logic    capture_in;
        logic    start;
        logic    load_pop;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    move_up;
        logic    move_down;
        logic    load_result;
    } cmd_t;

    typedef struct packed {
        logic is_pop;
        logic full;
        logic empty;
        logic at_root;
        logic has_child;
        logic child_wins;
        logic key_lt_parent;
    } sts_t;

endpackage

// ===== rtl/core/bmhq_ram.sv =====
// bmhq_ram: generic memory, one write port and two read ports,
// read data registered; no dependencies
`timescale 1ns / 1ps

module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/bmhq_ctrl.sv =====
// bmhq_ctrl: sequencer for push sift-up and pop sift-down
// depends on bmhq_pkg for state, command and status types
`timescale 1ns / 1ps

module bmhq_ctrl import bmhq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;

    assign can_load = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.is_pop)
                begin
                    state_next = sts.empty ? ST_FINISH : ST_POP_LOAD;
                end
                else
                begin
                    state_next = sts.full ? ST_FINISH : ST_UP_RD;
                end
            end
            ST_POP_LOAD:
            begin
                state_next = ST_DN_RD;
            end
            ST_UP_RD:
            begin
                state_next = sts.at_root ? ST_FINISH : ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                state_next = sts.key_lt_parent ? ST_UP_RD : ST_FINISH;
            end
            ST_DN_RD:
            begin
                state_next = sts.has_child ? ST_DN_CMP : ST_FINISH;
            end
            ST_DN_CMP:
            begin
                state_next = sts.child_wins ? ST_DN_RD : ST_FINISH;
            end
            ST_FINISH:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd          = '0;
        cmd.rd_sel   = RD_POP;
        cmd.wr_sel   = WR_NONE;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.capture_in = in_valid;
            end
            ST_START:
            begin
                cmd.start  = 1'b1;
                cmd.rd_sel = RD_POP;
            end
            ST_POP_LOAD:
            begin
                cmd.load_pop = 1'b1;
            end
            ST_UP_RD:
            begin
                cmd.rd_sel = RD_PARENT;
                if (sts.at_root)
                begin
                    cmd.wr_sel = WR_KEY;
                end
            end
            ST_UP_CMP:
            begin
                if (sts.key_lt_parent)
                begin
                    cmd.wr_sel  = WR_PARENT;
                    cmd.move_up = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                end
            end
            ST_DN_RD:
            begin
                cmd.rd_sel = RD_CHILD;
                if (!sts.has_child)
                begin
                    cmd.wr_sel = WR_KEY;
                end
            end
            ST_DN_CMP:
            begin
                if (sts.child_wins)
                begin
                    cmd.wr_sel    = WR_CHILD;
                    cmd.move_down = 1'b1;
                end
                else
                begin
                    cmd.wr_sel = WR_KEY;
                end
            end
            ST_FINISH:
            begin
                cmd.load_result = can_load;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // result register handshake
    always_comb
    begin
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/bmhq_dp.sv =====
// bmhq_dp: heap memory, position and count registers, key compare
// and result register; depends on bmhq_pkg and bmhq_ram
`timescale 1ns / 1ps

module bmhq_dp import bmhq_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    action,
    input  logic [KEY_PORT_W-1:0]   key_in,
    input  cmd_t                    cmd,
    output sts_t                    sts,
    output logic [KEY_PORT_W-1:0]   key_out,
    output logic                    ok,
    output logic [COUNT_PORT_W-1:0] count
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int KEXT = (KEY_WIDTH > KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
    localparam int CEXT = (CW > COUNT_PORT_W) ? CW : COUNT_PORT_W;

    logic                 key_signed_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 action_reg;
    logic                 action_next;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic [KEY_WIDTH-1:0] root_reg;
    logic [KEY_WIDTH-1:0] root_next;
    logic [AW-1:0]        pos_reg;
    logic [AW-1:0]        pos_next;
    logic                 ok_reg;
    logic                 ok_next;

    logic [KEY_PORT_W-1:0]   key_out_reg;
    logic                    ok_out_reg;
    logic [COUNT_PORT_W-1:0] count_out_reg;

    logic [KEXT-1:0]      key_in_ext;
    logic [KEXT-1:0]      root_ext;
    logic [CEXT-1:0]      count_ext;
    logic [KEY_WIDTH-1:0] key_in_kw;

    logic [CW-1:0]        last_idx;
    logic [AW-1:0]        parent_idx;
    logic [AW:0]          lc_idx;
    logic [AW:0]          rc_idx;
    logic [AW:0]          count_wide;
    logic                 rc_in_range;

    logic                 we;
    logic [AW-1:0]        raddr_a;
    logic [AW-1:0]        raddr_b;
    logic [KEY_WIDTH-1:0] wdata;
    logic [KEY_WIDTH-1:0] rdata_a;
    logic [KEY_WIDTH-1:0] rdata_b;

    logic                 left_lt;
    logic                 right_lt;
    logic [KEY_WIDTH-1:0] best_left;
    logic [KEY_WIDTH-1:0] child_data;
    logic [AW-1:0]        child_idx;

    function automatic logic key_less(
        input logic [KEY_WIDTH-1:0] a,
        input logic [KEY_WIDTH-1:0] b,
        input logic                 sgn
    );
        logic [KEY_WIDTH-1:0] flip;
        begin
            flip            = '0;
            flip[KEY_WIDTH-1] = sgn;
            return (a ^ flip) < (b ^ flip);
        end
    endfunction

    assign key_in_ext = KEXT'(key_in);
    assign key_in_kw  = key_in_ext[KEY_WIDTH-1:0];

    // heap index arithmetic
    assign last_idx    = count_reg - CW'(1);
    assign parent_idx  = AW'((pos_reg - AW'(1)) >> 1);
    assign lc_idx      = {pos_reg, 1'b1};
    assign rc_idx      = {pos_reg, 1'b0} + (AW + 1)'(2);
    assign count_wide  = (AW + 1)'(count_reg);
    assign rc_in_range = rc_idx < count_wide;

    // child selection, left wins ties
    assign left_lt    = key_less(rdata_a, key_reg, key_signed_reg);
    assign best_left  = left_lt ? rdata_a : key_reg;
    assign right_lt   = rc_in_range && key_less(rdata_b, best_left, key_signed_reg);
    assign child_data = right_lt ? rdata_b : rdata_a;
    assign child_idx  = right_lt ? rc_idx[AW-1:0] : lc_idx[AW-1:0];

    assign sts.is_pop        = (action_reg == ACT_POP);
    assign sts.full          = (count_reg == CW'(CAPACITY));
    assign sts.empty         = (count_reg == '0);
    assign sts.at_root       = (pos_reg == '0);
    assign sts.has_child     = lc_idx < count_wide;
    assign sts.child_wins    = left_lt || right_lt;
    assign sts.key_lt_parent = key_less(key_reg, rdata_a, key_signed_reg);

    always_comb
    begin
        raddr_a = '0;
        raddr_b = '0;
        unique case (cmd.rd_sel)
            RD_POP:
            begin
                raddr_a = '0;
                raddr_b = last_idx[AW-1:0];
            end
            RD_PARENT:
            begin
                raddr_a = parent_idx;
            end
            RD_CHILD:
            begin
                raddr_a = lc_idx[AW-1:0];
                raddr_b = rc_idx[AW-1:0];
            end
            default:
            begin
                raddr_a = '0;
            end
        endcase
    end

    always_comb
    begin
        we    = 1'b1;
        wdata = key_reg;
        unique case (cmd.wr_sel)
            WR_NONE:
            begin
                we = 1'b0;
            end
            WR_KEY:
            begin
                wdata = key_reg;
            end
            WR_PARENT:
            begin
                wdata = rdata_a;
            end
            WR_CHILD:
            begin
                wdata = child_data;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    bmhq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_heap_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (pos_reg),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        action_next = action_reg;
        key_next    = key_reg;
        root_next   = root_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        ok_next     = ok_reg;
        if (cmd.capture_in)
        begin
            action_next = action;
            key_next    = key_in_kw;
        end
        if (cmd.start)
        begin
            if (sts.is_pop)
            begin
                ok_next  = !sts.empty;
                pos_next = '0;
                if (!sts.empty)
                begin
                    count_next = last_idx;
                end
            end
            else
            begin
                ok_next = !sts.full;
                if (!sts.full)
                begin
                    pos_next   = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
            end
        end
        // root goes out, last entry becomes the key being sifted
        if (cmd.load_pop)
        begin
            root_next = rdata_a;
            key_next  = rdata_b;
        end
        if (cmd.move_up)
        begin
            pos_next = parent_idx;
        end
        if (cmd.move_down)
        begin
            pos_next = child_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_signed_reg <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                key_signed_reg <= cfg_data;
            end
            count_reg <= count_next;
        end
    end

    assign root_ext  = KEXT'(root_reg);
    assign count_ext = CEXT'(count_reg);

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        key_reg    <= key_next;
        root_reg   <= root_next;
        pos_reg    <= pos_next;
        ok_reg     <= ok_next;
        if (cmd.load_result)
        begin
            key_out_reg   <= (ok_reg && sts.is_pop) ? root_ext[KEY_PORT_W-1:0] : '0;
            ok_out_reg    <= ok_reg;
            count_out_reg <= count_ext[COUNT_PORT_W-1:0];
        end
    end

    assign key_out = key_out_reg;
    assign ok      = ok_out_reg;
    assign count   = count_out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_move_up_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_up |-> pos_reg != '0)
        else $error("sift-up step from the root");

    a_child_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.move_down |-> (AW + 1)'(child_idx) < count_wide)
        else $error("sift-down step to an entry outside the heap");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && !sts.is_pop && !sts.full) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not grow the heap by one");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start && sts.is_pop && !sts.empty) |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop did not shrink the heap by one");

endmodule

// ===== rtl/core/binary_min_heap_queue_top.sv =====
// a push is written at the end of the heap and sifts up; a pop moves the last entry to the root and sifts it down;
// each level moved takes one read and one write; a failed push (full) or pop (empty) only loads the result
// one item at a time, the next transfer is taken in the cycle after the result is loaded
// reset empties the heap (count zero) and selects unsigned compare; memory is not cleared
`timescale 1ns / 1ps

module binary_min_heap_queue_top import bmhq_pkg::*; #(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    action,
    input  logic [KEY_PORT_W-1:0]   key_in,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [KEY_PORT_W-1:0]   key_out,
    output logic                    ok,
    output logic [COUNT_PORT_W-1:0] count
);

    cmd_t cmd;
    sts_t sts;

    // configuration is taken on any cycle
    assign cfg_ready = 1'b1;

    bmhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bmhq_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .action    (action),
        .key_in    (key_in),
        .cmd       (cmd),
        .sts       (sts),
        .key_out   (key_out),
        .ok        (ok),
        .count     (count)
    );

endmodule
